@@ rtl/veh_pkg.sv @@
// ----------------------------------------------------------------------------
// veh_pkg
// Types and constants shared by the variable edge histogram and its checker.
// ----------------------------------------------------------------------------
package veh_pkg;

    // field widths
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int ENERGY_W = 32;
    localparam int FLUX_W   = 32;
    localparam int TOTAL_W  = 48;
    localparam int COUNT_W  = 5;

    // largest accumulator value, Q32.16
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_EDGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE      = 2'd3;

    // register indexes
    localparam logic REG_EDGES_IN_USE = 1'b0;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_ACC  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

@@ rtl/variable_edge_histogram.sv @@
// ----------------------------------------------------------------------------
// variable_edge_histogram
// Energy spectrum histogram with software-loaded ascending bin edges and
// saturating Q32.16 flux accumulators, one per bin.
// ----------------------------------------------------------------------------
//  channel   signals                        direction
//  in        in_valid / in_ready + fields   item in: load edge, add sample, read
//  out       out_valid / out_ready + fields one result item per input item
//  cfg       psel penable pwrite paddr ...  edges_in_use register, byte 0
//
//  load edge, read bin and unused kind: the result is registered at accept
//  and moves from the done state to the output register.
//  add sample: one 32-bit comparator walks the edges one per cycle, then one
//  49-bit adder does the accumulator update.
//  rst_n clears edges, accumulators and edges_in_use at once.
//  in_ready is high only while the sequencer is idle; a result waiting on
//  out_ready holds the next result back in the done state.
// ----------------------------------------------------------------------------
module variable_edge_histogram
    import veh_pkg::*;
#(
    parameter int MAX_EDGES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // item input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KIND_W-1:0]    kind,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [ENERGY_W-1:0]  edge_value,
    input  logic [ENERGY_W-1:0]  sample_energy,
    input  logic [FLUX_W-1:0]    sample_flux,
    // result output
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SLOT_W-1:0]    bin_index,
    output logic [TOTAL_W-1:0]   bin_total,
    output logic                 hit,
    output logic                 saturated,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // edges past slot 15 can never be loaded and are not stored, so bins above
    // that point never hit; storage stops at sixteen entries or MAX_EDGES, whichever is smaller
    localparam int Depth = (MAX_EDGES < 16) ? MAX_EDGES : 16;
    localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    edges_in_use_reg;
    logic [ENERGY_W-1:0]   edges_reg [Depth];
    logic [TOTAL_W-1:0]    totals_reg [Depth];
    logic [ENERGY_W-1:0]   energy_reg;
    logic [FLUX_W-1:0]     flux_reg;
    logic [IdxW-1:0]       idx_reg;
    logic [IdxW-1:0]       bin_reg;
    logic                  prev_ge_reg;

    logic [SLOT_W-1:0]     res_index_reg;
    logic [TOTAL_W-1:0]    res_total_reg;
    logic                  res_hit_reg;
    logic                  res_sat_reg;

    logic                  out_valid_reg;
    logic [SLOT_W-1:0]     out_index_reg;
    logic [TOTAL_W-1:0]    out_total_reg;
    logic                  out_hit_reg;
    logic                  out_sat_reg;

    logic                  in_fire;
    logic                  cfg_write;
    logic [COUNT_W-1:0]    n_eff;
    logic [COUNT_W-1:0]    last_idx;
    logic                  slot_ok;
    logic [IdxW-1:0]       slot_idx;
    logic                  ge;
    logic                  scan_last;
    logic [TOTAL_W:0]      sum;
    logic                  sum_ovf;
    logic                  out_free;

    // handshakes
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || out_ready;

    // configuration read side
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EDGES_IN_USE)
                  ? {{(32-COUNT_W){1'b0}}, edges_in_use_reg} : 32'd0;

    // edges taking part, clamped to storage
    assign n_eff    = (edges_in_use_reg > COUNT_W'(Depth))
                    ? COUNT_W'(Depth) : edges_in_use_reg;
    assign last_idx = n_eff - COUNT_W'(1);

    // slot decode
    assign slot_ok  = ({1'b0, slot} < COUNT_W'(Depth));
    assign slot_idx = IdxW'(slot);

    // shared comparator: energy against the edge under the scan index
    assign ge        = (energy_reg >= edges_reg[idx_reg]);
    assign scan_last = (COUNT_W'(idx_reg) == last_idx);

    // shared adder with saturation
    assign sum     = {1'b0, totals_reg[bin_reg]} + (TOTAL_W+1)'(flux_reg);
    assign sum_ovf = sum[TOTAL_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == KIND_ADD && n_eff >= COUNT_W'(2))
                        state_next = ST_SCAN;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    if (!ge)
                        state_next = ST_DONE;
                end
                else if (prev_ge_reg && !ge)
                    state_next = ST_ACC;
                else if (scan_last)
                    state_next = ST_DONE;
            end
            ST_ACC:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer, storage and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            edges_in_use_reg <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < Depth; i++)
            begin
                edges_reg[i]  <= '0;
                totals_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // register write
            if (cfg_write && paddr[2] == REG_EDGES_IN_USE)
                edges_in_use_reg <= pwdata[COUNT_W-1:0];

            // accept an item
            if (in_fire)
            begin
                energy_reg  <= sample_energy;
                flux_reg    <= sample_flux;
                idx_reg     <= '0;
                prev_ge_reg <= 1'b0;
                res_hit_reg <= 1'b0;
                res_sat_reg <= 1'b0;
                unique case (kind)
                    KIND_LOAD_EDGE:
                    begin
                        res_index_reg <= slot;
                        res_total_reg <= '0;
                        if (slot_ok)
                            edges_reg[slot_idx] <= edge_value;
                    end
                    KIND_READ:
                    begin
                        res_index_reg <= slot;
                        res_total_reg <= slot_ok ? totals_reg[slot_idx] : '0;
                    end
                    KIND_ADD, KIND_NONE:
                    begin
                        res_index_reg <= '0;
                        res_total_reg <= '0;
                    end
                endcase
            end

            // edge scan, one edge per cycle
            if (state_reg == ST_SCAN)
            begin
                prev_ge_reg <= ge;
                bin_reg     <= idx_reg - IdxW'(1);
                if (!scan_last)
                    idx_reg <= idx_reg + IdxW'(1);
            end

            // accumulator update
            if (state_reg == ST_ACC)
            begin
                totals_reg[bin_reg] <= sum_ovf ? TOTAL_MAX : sum[TOTAL_W-1:0];
                res_index_reg       <= SLOT_W'(bin_reg);
                res_total_reg       <= sum_ovf ? TOTAL_MAX : sum[TOTAL_W-1:0];
                res_hit_reg         <= 1'b1;
                res_sat_reg         <= sum_ovf;
            end

            // output register
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_index_reg <= res_index_reg;
                out_total_reg <= res_total_reg;
                out_hit_reg   <= res_hit_reg;
                out_sat_reg   <= res_sat_reg;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_index = out_index_reg;
    assign bin_total = out_total_reg;
    assign hit       = out_hit_reg;
    assign saturated = out_sat_reg;

endmodule

@@ rtl/veh_checker.sv @@
// ----------------------------------------------------------------------------
// veh_checker
// Port-level checks for the variable edge histogram, bound to the top level.
// ----------------------------------------------------------------------------
module veh_checker
    import veh_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SLOT_W-1:0]   bin_index,
    input logic [TOTAL_W-1:0]  bin_total,
    input logic                hit,
    input logic                saturated
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_total)
            && $stable(bin_index) && $stable(hit) && $stable(saturated))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a clip only comes with a hit
    a_sat_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> hit)
        else $error("saturated without hit");

    // a clipped accumulator reads as the maximum
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> bin_total == TOTAL_MAX)
        else $error("saturated total is not the maximum");

endmodule

bind variable_edge_histogram veh_checker u_veh_checker (.*);
